### rtl/sawbc_pkg.sv
// package: sizes, row and request types, and state codes of the cache
`timescale 1ns / 1ps
package sawbc_pkg;

	localparam int SET_COUNT  = 32;
	localparam int WAY_COUNT  = 4;
	localparam int LINE_BYTES = 8;
	localparam int MEM_BYTES  = 65536;

	localparam int ADDR_W  = 16;
	localparam int BYTE_W  = 8;
	localparam int OFS_W   = $clog2(LINE_BYTES);
	localparam int SET_W   = $clog2(SET_COUNT);
	localparam int TAG_W   = ADDR_W - OFS_W - SET_W;
	localparam int WAY_W   = $clog2(WAY_COUNT);
	localparam int AGE_W   = $clog2(WAY_COUNT);
	localparam int LINE_W  = BYTE_W * LINE_BYTES;
	localparam int LADDR_W = ADDR_W - OFS_W;
	localparam int MROWS   = MEM_BYTES / LINE_BYTES;
	localparam int MROW_W  = $clog2(MROWS);

	// access kinds
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic              valid;
		logic              dirty;
		logic [AGE_W-1:0]  age;
		logic [LINE_W-1:0] data;
	} way_t;

	typedef way_t [WAY_COUNT-1:0] row_t;

	typedef struct packed {
		logic              wr_en;
		logic              rd_en;
		logic [MROW_W-1:0] row;
	} bk_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_WBACK,
		ST_FILL_RD,
		ST_FILL,
		ST_UPDATE
	} state_t;

	function automatic row_t reset_row();
		row_t r;
		r = '0;
		for (int w = 0; w < WAY_COUNT; w++) begin
			r[w].age = AGE_W'(WAY_COUNT - 1 - w);
		end
		return r;
	endfunction

	function automatic logic [MROW_W-1:0] mem_row(input logic [TAG_W-1:0] tag,
		input logic [SET_W-1:0] set_idx);
		logic [LADDR_W-1:0] la;
		la = {tag, set_idx};
		return la[MROW_W-1:0];
	endfunction

endpackage

### rtl/sawbc_if.sv
// interfaces: request and response channels of the cache
`timescale 1ns / 1ps
interface sawbc_req_if import sawbc_pkg::*;;
	logic              valid;
	logic              ready;
	logic              operation;
	logic [ADDR_W-1:0] address;
	logic [BYTE_W-1:0] write_data;

	modport source (output valid, operation, address, write_data, input ready);
	modport sink (input valid, operation, address, write_data, output ready);
	modport mon (input valid, ready, operation, address, write_data);
endinterface

interface sawbc_rsp_if import sawbc_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] read_data;
	logic              line_dirty;
	logic              hit;

	modport source (output valid, read_data, line_dirty, hit, input ready);
	modport sink (input valid, read_data, line_dirty, hit, output ready);
	modport mon (input valid, ready, read_data, line_dirty, hit);
endinterface

### rtl/set_assoc_writeback_cache_unit.sv
// top level: 4-way, 32-set write-back cache with 8-byte lines and LRU replacement
// in front of a zeroed backing memory. One item is worked at a time. A read
// hit passes the lookup and update states, a clean miss also fill read and
// fill, and a dirty miss also write-back before those; the next item can be
// taken as soon as the result appears (writes give no result and pass the
// same states). The steps are set by the single-port set memory (read,
// then write back of the whole set row) and the line-wide backing memory (one
// write-back row, one fill row). After reset the backing memory is swept to
// zero, one line per cycle, over all MEM_BYTES / LINE_BYTES = 8192 lines;
// req.ready stays low during the sweep. A finished result waits in an output
// register while the next item is taken; a read that finishes while that
// register is still held waits until the result is taken.
`timescale 1ns / 1ps
module set_assoc_writeback_cache_unit import sawbc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	sawbc_req_if.sink  req,
	sawbc_rsp_if.source rsp
);

	row_t set_mem [SET_COUNT];

	state_t state_q, state_nx;

	logic [SET_COUNT-1:0] row_valid_q;
	row_t                 set_rd_s1;
	logic                 rowok_s1;

	logic              op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [BYTE_W-1:0] wdata_q;
	row_t              row_q;
	logic [WAY_W-1:0]  way_q;
	logic              hit_q;
	logic              dold_q;

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_data_q;
	logic              out_dirty_q;
	logic              out_hit_q;

	logic [SET_W-1:0]  a_set;
	logic [SET_W-1:0]  q_set;
	logic [TAG_W-1:0]  q_tag;
	logic [OFS_W-1:0]  q_ofs;

	row_t              cur_row;
	logic              lk_hit;
	logic [WAY_W-1:0]  lk_hit_way;
	logic [WAY_W-1:0]  lk_victim;
	logic [WAY_W-1:0]  lk_way;
	logic              lk_wback;

	row_t              upd_row;
	logic [AGE_W-1:0]  old_age;

	logic              acc;
	logic              ready;
	logic              upd_go;
	bk_req_t           bk_req;
	logic [LINE_W-1:0] bk_rdata;
	logic              bk_busy;

	sawbc_backing_mem u_backing (
		.clk    (clk),
		.arst_n (arst_n),
		.bk_req (bk_req),
		.wdata  (row_q[way_q].data),
		.rdata  (bk_rdata),
		.busy   (bk_busy)
	);

	assign a_set = req.address[OFS_W +: SET_W];
	assign q_set = addr_q[OFS_W +: SET_W];
	assign q_tag = addr_q[OFS_W + SET_W +: TAG_W];
	assign q_ofs = addr_q[OFS_W-1:0];

	// tag compare and victim choice
	always_comb begin
		cur_row    = rowok_s1 ? set_rd_s1 : reset_row();
		lk_hit     = 1'b0;
		lk_hit_way = '0;
		lk_victim  = '0;
		for (int w = 0; w < WAY_COUNT; w++) begin
			if (!lk_hit && cur_row[w].valid && cur_row[w].tag == q_tag) begin
				lk_hit     = 1'b1;
				lk_hit_way = WAY_W'(w);
			end
		end
		for (int w = 1; w < WAY_COUNT; w++) begin
			if (cur_row[w].age > cur_row[lk_victim].age) begin
				lk_victim = WAY_W'(w);
			end
		end
		lk_way   = lk_hit ? lk_hit_way : lk_victim;
		lk_wback = !lk_hit && cur_row[lk_victim].valid && cur_row[lk_victim].dirty;
	end

	// age, byte and dirty update of the set row
	always_comb begin
		upd_row = row_q;
		old_age = row_q[way_q].age;
		for (int w = 0; w < WAY_COUNT; w++) begin
			if (row_q[w].age < old_age) begin
				upd_row[w].age = row_q[w].age + 1'b1;
			end
		end
		upd_row[way_q].age = '0;
		if (op_q == OP_WRITE) begin
			upd_row[way_q].data[{q_ofs, 3'b000} +: BYTE_W] = wdata_q;
			upd_row[way_q].dirty = 1'b1;
		end else if (!hit_q) begin
			upd_row[way_q].dirty = 1'b0;
		end
	end

	// fsm outputs
	always_comb begin
		ready        = 1'b0;
		upd_go       = 1'b0;
		bk_req.wr_en = 1'b0;
		bk_req.rd_en = 1'b0;
		bk_req.row   = mem_row(q_tag, q_set);
		unique case (state_q)
			ST_IDLE: begin
				ready = !bk_busy;
			end
			ST_WBACK: begin
				bk_req.wr_en = 1'b1;
				bk_req.row   = mem_row(row_q[way_q].tag, q_set);
			end
			ST_FILL_RD: begin
				bk_req.rd_en = 1'b1;
			end
			ST_UPDATE: begin
				upd_go = (op_q == OP_WRITE) || !out_valid_q || rsp.ready;
			end
			default: begin
			end
		endcase
	end

	assign acc       = req.valid && ready;
	assign req.ready = ready;

	// fsm next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					state_nx = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (lk_hit) begin
					state_nx = ST_UPDATE;
				end else if (lk_wback) begin
					state_nx = ST_WBACK;
				end else begin
					state_nx = ST_FILL_RD;
				end
			end
			ST_WBACK:   state_nx = ST_FILL_RD;
			ST_FILL_RD: state_nx = ST_FILL;
			ST_FILL:    state_nx = ST_UPDATE;
			ST_UPDATE: begin
				if (upd_go) begin
					state_nx = ST_IDLE;
				end
			end
			default:    state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			row_valid_q <= '0;
		end else begin
			state_q <= state_nx;
			if (upd_go) begin
				row_valid_q[q_set] <= 1'b1;
			end
			if (upd_go && op_q == OP_READ) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// set memory
	always_ff @(posedge clk) begin
		if (acc) begin
			set_rd_s1 <= set_mem[a_set];
		end
		if (upd_go) begin
			set_mem[q_set] <= upd_row;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_q     <= req.operation;
			addr_q   <= req.address;
			wdata_q  <= req.write_data;
			rowok_s1 <= row_valid_q[a_set];
		end
		if (state_q == ST_LOOKUP) begin
			row_q  <= cur_row;
			way_q  <= lk_way;
			hit_q  <= lk_hit;
			dold_q <= cur_row[lk_way].dirty;
		end
		if (state_q == ST_FILL) begin
			row_q[way_q].data  <= bk_rdata;
			row_q[way_q].tag   <= q_tag;
			row_q[way_q].valid <= 1'b1;
		end
		if (upd_go && op_q == OP_READ) begin
			out_data_q  <= row_q[way_q].data[{q_ofs, 3'b000} +: BYTE_W];
			out_dirty_q <= dold_q;
			out_hit_q   <= hit_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.read_data  = out_data_q;
	assign rsp.line_dirty = out_dirty_q;
	assign rsp.hit        = out_hit_q;

endmodule

### rtl/sawbc_backing_mem.sv
// backing memory: line-wide rows with a zero sweep after reset
`timescale 1ns / 1ps
module sawbc_backing_mem import sawbc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  bk_req_t           bk_req,
	input  logic [LINE_W-1:0] wdata,
	output logic [LINE_W-1:0] rdata,
	output logic              busy
);

	logic [LINE_W-1:0] mem [MROWS];
	logic [LINE_W-1:0] rdata_q;
	logic              clr_q;
	logic [MROW_W-1:0] clr_row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_row_q <= '0;
		end else if (clr_q) begin
			clr_row_q <= clr_row_q + 1'b1;
			if (clr_row_q == MROW_W'(MROWS - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_row_q] <= '0;
		end else if (bk_req.wr_en) begin
			mem[bk_req.row] <= wdata;
		end
		if (bk_req.rd_en) begin
			rdata_q <= mem[bk_req.row];
		end
	end

	assign rdata = rdata_q;
	assign busy  = clr_q;

endmodule

### rtl/sawbc_check.sv
// checker: port-level assertions on the cache and its bind to the top level
`timescale 1ns / 1ps
module sawbc_check import sawbc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [BYTE_W-1:0] rsp_read_data,
	input logic              rsp_line_dirty,
	input logic              rsp_hit
);

	// response stays offered until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped before taken");

	// stalled response keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_read_data) && $stable(rsp_line_dirty)
			&& $stable(rsp_hit))
		else $error("stalled response changed");

	// one item at a time: no new item right after one is taken
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while lookup busy");

	// lookup comes before any result: no result rises while it runs
	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(rsp_valid))
		else $error("result appeared in the lookup cycle");

endmodule

bind set_assoc_writeback_cache_unit sawbc_check u_sawbc_check (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_read_data  (rsp.read_data),
	.rsp_line_dirty (rsp.line_dirty),
	.rsp_hit        (rsp.hit)
);

### tb/set_assoc_writeback_cache_unit_tb.sv
// testbench: byte reads and writes against a predicted 4-way write-back LRU cache
`timescale 1ns / 1ps
module set_assoc_writeback_cache_unit_tb;
	import sawbc_pkg::*;

	localparam int WATCHDOG_LIMIT = 50000;
	localparam int TAIL_CYCLES    = 20;
	localparam int DIRECTED_ROWS  = 22;

	typedef struct packed {
		logic [BYTE_W-1:0] read_data;
		logic              line_dirty;
		logic              hit;
	} read_result_t;

	typedef struct packed {
		logic              op;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] wdata;
		logic              typed;
		read_result_t      want;
	} access_row_t;

	// typed rows: reset contents, address extremes, hits on freshly written bytes
	localparam access_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{OP_READ,  16'h0000, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
		'{OP_READ,  16'hFFFF, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
		'{OP_WRITE, 16'h0000, 8'hFF, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{OP_READ,  16'h0000, 8'h00, 1'b1, '{8'hFF, 1'b1, 1'b1}},
		'{OP_WRITE, 16'hFFFF, 8'hA5, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{OP_READ,  16'hFFFF, 8'hFF, 1'b1, '{8'hA5, 1'b1, 1'b1}},
		'{OP_WRITE, 16'h0107, 8'h3C, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{OP_WRITE, 16'h0201, 8'h5A, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{OP_READ,  16'h0300, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
		'{OP_READ,  16'h0400, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{OP_READ,  16'h0000, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{OP_READ,  16'h0107, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{OP_WRITE, 16'h0500, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{OP_READ,  16'h0500, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{OP_READ,  16'h0201, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{OP_WRITE, 16'hFF00, 8'hFF, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{OP_READ,  16'hFFF8, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{OP_WRITE, 16'h00F8, 8'h01, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{OP_READ,  16'h01FF, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{OP_READ,  16'h02F8, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{OP_READ,  16'h03F8, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{OP_READ,  16'hFFFF, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}}
	};

	logic clk = 1'b0;
	logic arst_n;

	sawbc_req_if req_ch ();
	sawbc_rsp_if rsp_ch ();

	set_assoc_writeback_cache_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	// shadow of the cache and its backing memory
	logic [TAG_W-1:0]  way_tag   [SET_COUNT][WAY_COUNT];
	logic              way_valid [SET_COUNT][WAY_COUNT];
	logic              way_dirty [SET_COUNT][WAY_COUNT];
	logic [AGE_W-1:0]  way_age   [SET_COUNT][WAY_COUNT];
	logic [BYTE_W-1:0] way_bytes [SET_COUNT][WAY_COUNT][LINE_BYTES];
	logic [BYTE_W-1:0] shadow_mem [MEM_BYTES];

	read_result_t read_results_due [$];
	int mismatch_count = 0;
	int quiet_cycles = 0;
	int sender_idle_pct = 0;
	int receiver_idle_pct = 0;

	function automatic void clear_shadow();
		for (int s = 0; s < SET_COUNT; s++) begin
			for (int w = 0; w < WAY_COUNT; w++) begin
				way_valid[s][w] = 1'b0;
				way_dirty[s][w] = 1'b0;
				way_age[s][w]   = AGE_W'(WAY_COUNT - 1 - w);
			end
		end
		for (int m = 0; m < MEM_BYTES; m++) begin
			shadow_mem[m] = '0;
		end
	endfunction

	// returns 1 when the access produces a read result
	function automatic bit predict_read(input logic op, input logic [ADDR_W-1:0] addr,
		input logic [BYTE_W-1:0] wdata, output read_result_t res);
		logic [OFS_W-1:0]  ofs;
		logic [SET_W-1:0]  set_idx;
		logic [TAG_W-1:0]  tag;
		logic [ADDR_W-1:0] line_addr;
		logic [AGE_W-1:0]  old_age;
		int way;
		bit found;
		ofs     = addr[OFS_W-1:0];
		set_idx = addr[OFS_W +: SET_W];
		tag     = addr[ADDR_W-1 -: TAG_W];
		res     = '0;
		found   = 1'b0;
		way     = 0;
		for (int w = 0; w < WAY_COUNT; w++) begin
			if (!found && way_valid[set_idx][w] && way_tag[set_idx][w] == tag) begin
				way   = w;
				found = 1'b1;
			end
		end
		if (!found) begin
			for (int w = 1; w < WAY_COUNT; w++) begin
				if (way_age[set_idx][w] > way_age[set_idx][way]) way = w;
			end
			if (way_valid[set_idx][way] && way_dirty[set_idx][way]) begin
				line_addr = {way_tag[set_idx][way], set_idx, OFS_W'(0)};
				for (int b = 0; b < LINE_BYTES; b++) begin
					shadow_mem[ADDR_W'(line_addr + b)] = way_bytes[set_idx][way][b];
				end
			end
			line_addr = {tag, set_idx, OFS_W'(0)};
			for (int b = 0; b < LINE_BYTES; b++) begin
				way_bytes[set_idx][way][b] = shadow_mem[ADDR_W'(line_addr + b)];
			end
			way_tag[set_idx][way]   = tag;
			way_valid[set_idx][way] = 1'b1;
		end
		old_age = way_age[set_idx][way];
		for (int w = 0; w < WAY_COUNT; w++) begin
			if (way_age[set_idx][w] < old_age) way_age[set_idx][w] = way_age[set_idx][w] + 1'b1;
		end
		way_age[set_idx][way] = '0;
		if (op == OP_WRITE) begin
			way_bytes[set_idx][way][ofs] = wdata;
			way_dirty[set_idx][way]      = 1'b1;
			return 1'b0;
		end
		res.read_data  = way_bytes[set_idx][way][ofs];
		res.line_dirty = way_dirty[set_idx][way];
		res.hit        = found;
		if (!found) way_dirty[set_idx][way] = 1'b0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic send_access(input logic op, input logic [ADDR_W-1:0] addr,
		input logic [BYTE_W-1:0] wdata, input logic typed, input read_result_t want);
		read_result_t predicted;
		while ($urandom_range(99) < sender_idle_pct) begin
			req_ch.valid      <= 1'b0;
			req_ch.operation  <= 1'($urandom);
			req_ch.address    <= ADDR_W'($urandom);
			req_ch.write_data <= BYTE_W'($urandom);
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.operation  <= op;
		req_ch.address    <= addr;
		req_ch.write_data <= wdata;
		do @(posedge clk); while (!req_ch.ready);
		if (predict_read(op, addr, wdata, predicted)) begin
			read_results_due.push_back(typed ? want : predicted);
		end
	endtask

	task automatic wait_for_drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (read_results_due.size() != 0);
	endtask

	// most items hit a few hot sets with a small tag pool so lines get evicted
	task automatic run_random_phase(input int item_count, input int send_pct,
		input int recv_pct);
		logic [SET_W-1:0]  hot_set [4];
		logic [TAG_W-1:0]  tag_pool [6];
		logic [ADDR_W-1:0] addr;
		sender_idle_pct   = send_pct;
		receiver_idle_pct = recv_pct;
		foreach (hot_set[i]) hot_set[i] = SET_W'($urandom_range(SET_COUNT - 1));
		foreach (tag_pool[i]) tag_pool[i] = TAG_W'($urandom);
		repeat (item_count) begin
			if ($urandom_range(99) < 80) begin
				addr = {tag_pool[$urandom_range(5)], hot_set[$urandom_range(3)],
					OFS_W'($urandom_range(LINE_BYTES - 1))};
			end else begin
				addr = ADDR_W'($urandom);
			end
			send_access(1'($urandom), addr, BYTE_W'($urandom), 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
	end

	always @(posedge clk) begin : read_check
		read_result_t got;
		read_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.read_data  = rsp_ch.read_data;
			got.line_dirty = rsp_ch.line_dirty;
			got.hit        = rsp_ch.hit;
			if (read_results_due.size() == 0) begin
				report_mismatch($sformatf("read result with none due: %p", got));
			end else begin
				want = read_results_due.pop_front();
				if (got.read_data !== want.read_data)
					report_mismatch($sformatf("read_data %h, want %h", got.read_data,
						want.read_data));
				if (got.line_dirty !== want.line_dirty)
					report_mismatch($sformatf("line_dirty %b, want %b", got.line_dirty,
						want.line_dirty));
				if (got.hit !== want.hit)
					report_mismatch($sformatf("hit %b, want %b", got.hit, want.hit));
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: %0d cycles with no item accepted", quiet_cycles);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n            <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.operation  <= OP_READ;
		req_ch.address    <= '0;
		req_ch.write_data <= '0;
		clear_shadow();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		sender_idle_pct   = 31;
		receiver_idle_pct = 47;
		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			send_access(DIRECTED[r].op, DIRECTED[r].addr, DIRECTED[r].wdata,
				DIRECTED[r].typed, DIRECTED[r].want);
		end

		run_random_phase(184, 31, 47);
		wait_for_drain();
		run_random_phase(183, 47, 31);
		wait_for_drain();
		run_random_phase(183, 0, 0);
		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
